### hdl/trs_pkg.sv
// Shared types, constants and byte tables for the touch report serializer.
// Depends on nothing; every other file imports it.
package trs_pkg;

    localparam int COORD_BITS = 16;
    localparam int IN_COORD_W = 16;
    localparam int CW         = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
    localparam int CGRP       = (CW + 6) / 7;
    localparam int CLEN_W     = $clog2(CGRP + 1);
    localparam int STAMP_W    = 30;
    localparam int SGRP       = (STAMP_W + 6) / 7;
    localparam int SLEN_W     = $clog2(SGRP + 1);
    localparam int IDX_W      = 3;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]         action;
        logic [CW-1:0]      x;
        logic [CW-1:0]      y;
        logic [STAMP_W-1:0] stamp;
        logic [SLEN_W-1:0]  ns;
        logic [CLEN_W-1:0]  nx;
        logic [CLEN_W-1:0]  ny;
    } trs_desc_t;

    typedef struct packed {
        logic busy;
        logic loading;
    } trs_back_status_t;

    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        begin
            case (idx)
                3'd0:    b = 8'h02;
                3'd1:    b = 8'h0b;
                3'd2:    b = 8'h03;
                3'd3:    b = 8'h00;
                3'd4:    b = 8'h80;
                3'd5:    b = 8'h01;
                default: b = 8'h08;
            endcase
            return b;
        end
    endfunction

    function automatic logic [7:0] size_byte(input logic [1:0] idx);
        logic [7:0] b;
        begin
            case (idx)
                2'd0:    b = 8'h1a;
                2'd1:    b = 8'h09;
                2'd2:    b = 8'h0a;
                default: b = 8'h03;
            endcase
            return b;
        end
    endfunction

    function automatic logic [7:0] tail_byte(input logic [1:0] idx);
        logic [7:0] b;
        begin
            case (idx)
                2'd0:    b = 8'h10;
                2'd1:    b = 8'h00;
                default: b = 8'h18;
            endcase
            return b;
        end
    endfunction

endpackage

### hdl/trs_front.sv
// Front end: takes a touch event and works out the LEB128 lengths of its fields.
// Depends on trs_pkg.
module trs_front
    import trs_pkg::*;
(
    input  logic [1:0]  action,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [29:0] stamp_ns,
    output trs_desc_t   desc
);

    logic [CW-1:0]     x;
    logic [CW-1:0]     y;
    logic [CLEN_W-1:0] nx;
    logic [CLEN_W-1:0] ny;
    logic [SLEN_W-1:0] ns;

    assign x = pos_x[CW-1:0];
    assign y = pos_y[CW-1:0];

    always_comb
    begin
        nx = CLEN_W'(1);
        ny = CLEN_W'(1);
        ns = SLEN_W'(1);
        for (int g = 1; g < CGRP; g++)
        begin
            if ((x >> (7 * g)) != '0)
                nx = CLEN_W'(g + 1);
            if ((y >> (7 * g)) != '0)
                ny = CLEN_W'(g + 1);
        end
        for (int g = 1; g < SGRP; g++)
        begin
            if ((stamp_ns >> (7 * g)) != '0)
                ns = SLEN_W'(g + 1);
        end
    end

    always_comb
    begin
        desc.action = action;
        desc.x      = x;
        desc.y      = y;
        desc.stamp  = stamp_ns;
        desc.ns     = ns;
        desc.nx     = nx;
        desc.ny     = ny;
    end

endmodule

### hdl/trs_queue.sv
// Short request queue between the front and back ends.
// Depends on trs_pkg.
module trs_queue
    import trs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  trs_desc_t         wr_data,
    output logic              full,
    input  logic              rd_en,
    output trs_desc_t         rd_data,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    trs_desc_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### hdl/trs_back.sv
// Back end: walks one request through the message layout into an output register,
// one byte per cycle while that register is free or being popped. Depends on trs_pkg.
module trs_back
    import trs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  trs_desc_t        q_data,
    input  logic             q_empty,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic             last,
    output trs_back_status_t status
);

    typedef enum logic [2:0] {
        SEG_HDR,
        SEG_STAMP,
        SEG_SIZE,
        SEG_TAG,
        SEG_COORD,
        SEG_TAIL,
        SEG_ACT
    } seg_t;

    localparam logic [1:0] COORD_X = 2'd0;
    localparam logic [1:0] COORD_Y = 2'd1;
    localparam logic [1:0] COORD_Z = 2'd2;

    seg_t             seg_reg,   seg_next;
    logic [IDX_W-1:0] idx_reg,   idx_next;
    logic [1:0]       csel_reg,  csel_next;
    logic             busy_reg,  busy_next;
    logic             ov_reg,    ov_next;
    logic [7:0]       byte_reg,  byte_next;
    logic             last_reg,  last_next;
    trs_desc_t        cur_reg,   cur_next;

    logic                 out_free;
    logic                 step;
    logic [7:0]           b;
    logic                 seg_done;
    logic [7:0]           total;
    logic [CGRP*7-1:0]    cval;
    logic [CLEN_W-1:0]    clen;
    logic [SGRP*7-1:0]    sval;
    logic [6:0]           cgrp;
    logic [6:0]           sgrp;
    logic                 c_more;
    logic                 s_more;

    assign out_free = !ov_reg || pop;
    assign step     = busy_reg && out_free;
    assign q_pop    = !busy_reg && !q_empty;
    assign total    = 8'(cur_reg.nx) + 8'(cur_reg.ny) + 8'd1;
    assign sval     = (SGRP*7)'(cur_reg.stamp);

    always_comb
    begin
        unique case (csel_reg)
            COORD_X: begin cval = (CGRP*7)'(cur_reg.x); clen = cur_reg.nx; end
            COORD_Y: begin cval = (CGRP*7)'(cur_reg.y); clen = cur_reg.ny; end
            default: begin cval = '0; clen = CLEN_W'(1); end
        endcase
    end

    always_comb
    begin
        cgrp = '0;
        sgrp = '0;
        for (int g = 0; g < CGRP; g++)
        begin
            if (idx_reg == IDX_W'(g))
                cgrp = cval[7*g +: 7];
        end
        for (int g = 0; g < SGRP; g++)
        begin
            if (idx_reg == IDX_W'(g))
                sgrp = sval[7*g +: 7];
        end
    end

    assign c_more = (idx_reg != IDX_W'(clen - 1'b1));
    assign s_more = (idx_reg != IDX_W'(cur_reg.ns - 1'b1));

    always_comb
    begin
        unique case (seg_reg)
            SEG_HDR:   begin b = hdr_byte(idx_reg);             seg_done = (idx_reg == 3'd6); end
            SEG_STAMP: begin b = {s_more, sgrp};                seg_done = !s_more;           end
            SEG_SIZE:
            begin
                b = size_byte(idx_reg[1:0]);
                if (idx_reg[0])
                    b = b + total;
                seg_done = (idx_reg == 3'd3);
            end
            SEG_TAG:   begin b = {3'b000, 2'(csel_reg + 2'd1), 3'b000}; seg_done = 1'b1; end
            SEG_COORD: begin b = {c_more, cgrp};                seg_done = !c_more;           end
            SEG_TAIL:  begin b = tail_byte(idx_reg[1:0]);       seg_done = (idx_reg == 3'd2); end
            SEG_ACT:   begin b = {6'd0, cur_reg.action};        seg_done = 1'b1;              end
            default:   begin b = 8'h00;                         seg_done = 1'b1;              end
        endcase
    end

    always_comb
    begin
        seg_next  = seg_reg;
        idx_next  = idx_reg;
        csel_next = csel_reg;
        busy_next = busy_reg;
        ov_next   = ov_reg;
        byte_next = byte_reg;
        last_next = last_reg;
        cur_next  = cur_reg;
        if (ov_reg && pop)
            ov_next = 1'b0;
        if (q_pop)
        begin
            cur_next  = q_data;
            busy_next = 1'b1;
            seg_next  = SEG_HDR;
            idx_next  = '0;
            csel_next = COORD_X;
        end
        if (step)
        begin
            ov_next   = 1'b1;
            byte_next = b;
            last_next = (seg_reg == SEG_ACT);
            idx_next  = idx_reg + 1'b1;
            if (seg_done)
            begin
                idx_next = '0;
                unique case (seg_reg)
                    SEG_HDR:   seg_next = SEG_STAMP;
                    SEG_STAMP: seg_next = SEG_SIZE;
                    SEG_SIZE:  seg_next = SEG_TAG;
                    SEG_TAG:   seg_next = SEG_COORD;
                    SEG_COORD:
                    begin
                        if (csel_reg == COORD_Z)
                            seg_next = SEG_TAIL;
                        else
                        begin
                            seg_next  = SEG_TAG;
                            csel_next = csel_reg + 2'd1;
                        end
                    end
                    SEG_TAIL:  seg_next = SEG_ACT;
                    SEG_ACT:   busy_next = 1'b0;
                    default:   seg_next = SEG_HDR;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg  <= SEG_HDR;
            idx_reg  <= '0;
            csel_reg <= COORD_X;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            seg_reg  <= seg_next;
            idx_reg  <= idx_next;
            csel_reg <= csel_next;
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        cur_reg  <= cur_next;
    end

    assign empty          = !ov_reg;
    assign out_byte       = byte_reg;
    assign last           = last_reg;
    assign status.busy    = busy_reg;
    assign status.loading = q_pop;

endmodule

### hdl/touch_report_serializer_unit.sv
// Top level of the touch report serializer: front end, request queue, back end.
// Depends on trs_pkg, trs_front, trs_queue and trs_back.
//
// Each accepted touch event becomes one report message of 22 to 30 bytes, sent
// one byte per result with last set on the final byte. The back end emits one
// byte per cycle while pop keeps up, and loads the next request from the
// queue only once the final byte of a message is in the output register.
// Two requests can wait in the queue, so new events are taken while a message
// is still going out. The output register holds a byte until it is popped; the
// back end stalls while that byte waits and moves on in the cycle it is popped.
module touch_report_serializer_unit
    import trs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [29:0] stamp_ns,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last
);

    trs_desc_t         f_desc;
    trs_desc_t         q_data;
    logic              q_empty;
    logic              q_pop;
    logic [QCNT_W-1:0] q_count;
    trs_back_status_t  b_status;

    trs_front u_front (
        .action   (action),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .stamp_ns (stamp_ns),
        .desc     (f_desc)
    );

    trs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (f_desc),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty),
        .count   (q_count)
    );

    trs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_data),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .last     (last),
        .status   (b_status)
    );

`ifndef SYNTH
    a_qcount: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_last_action: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (out_byte[7:2] == 6'd0))
        else $error("last byte is not an action code");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && !b_status.busy) |=> b_status.busy)
        else $error("waiting request not picked up");

    a_load_pops: assert property (@(posedge clk) disable iff (!rst_n)
        b_status.loading |-> (!q_empty && !b_status.busy))
        else $error("load without a waiting request");
`endif

endmodule

### bench/tb_touch_report_serializer_unit.sv
`timescale 1ns / 1ps
// Testbench for touch_report_serializer_unit: queued touch events, a byte-level
// report predictor and an in-order checker on the popped bytes.
// Depends on trs_pkg and the serializer RTL.
module tb_touch_report_serializer_unit;
    import trs_pkg::*;

    localparam logic [1:0]  ACT_DOWN  = 2'd0;
    localparam logic [1:0]  ACT_UP    = 2'd1;
    localparam logic [1:0]  ACT_MOVE  = 2'd2;
    localparam logic [1:0]  ACT_UNDEF = 2'd3;

    localparam logic [55:0] REPORT_HEAD = 56'h02_0b_03_00_80_01_08;
    localparam logic [23:0] REPORT_TAIL = 24'h10_00_18;
    localparam logic [7:0]  SZ_OUTER    = 8'h1a;
    localparam logic [7:0]  SZ_TOUCH    = 8'h09;
    localparam logic [7:0]  SZ_LIST     = 8'h0a;
    localparam logic [7:0]  SZ_POINT    = 8'h03;
    localparam logic [7:0]  TAG_X       = 8'h08;
    localparam logic [7:0]  TAG_Y       = 8'h10;
    localparam logic [7:0]  TAG_Z       = 8'h18;

    localparam int RANDOM_EVENTS = 450;
    localparam int STALL_AFTER   = 120;
    localparam int STALL_CYCLES  = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 40;

    typedef struct {
        logic [1:0]  action;
        logic [15:0] x;
        logic [15:0] y;
        logic [29:0] stamp;
    } touch_ev_t;

    typedef struct {
        logic [7:0] b;
        logic       lst;
    } report_byte_t;

    typedef struct {
        logic [39:0] bytes;
        int unsigned n;
    } leb_t;

    typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        push     = 1'b0;
    logic        full;
    logic [1:0]  action   = '0;
    logic [15:0] pos_x    = '0;
    logic [15:0] pos_y    = '0;
    logic [29:0] stamp_ns = '0;
    logic        empty;
    logic        pop      = 1'b0;
    logic [7:0]  out_byte;
    logic        last;

    touch_ev_t    touch_q[$];
    report_byte_t report_q[$];

    logic        req_fire     = 1'b0;
    int          gap_left     = 0;
    int          burst_left   = 0;
    int          stall_left   = 0;
    bit          stall_done   = 1'b0;
    rx_mode_t    rx_mode      = RX_STREAM;
    int          mode_left    = 0;
    int          tick         = 0;
    int          events_in    = 0;
    int          bytes_seen   = 0;
    int          msgs_seen    = 0;
    int          full_cycles  = 0;
    int          errors       = 0;
    int          cycles       = 0;

    touch_report_serializer_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .action   (action),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .stamp_ns (stamp_ns),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic leb_t leb_encode(input logic [31:0] v);
        leb_t       e;
        logic [7:0] grp;
        e.bytes = '0;
        e.n     = 0;
        grp     = {1'b0, v[6:0]};
        v       = v >> 7;
        while (v != 0)
        begin
            e.bytes[8*e.n +: 8] = grp | 8'h80;
            e.n++;
            grp = {1'b0, v[6:0]};
            v   = v >> 7;
        end
        e.bytes[8*e.n +: 8] = grp;
        e.n++;
        return e;
    endfunction

    function automatic void expect_byte(input logic [7:0] b, input logic lst);
        report_byte_t r;
        r.b   = b;
        r.lst = lst;
        report_q.push_back(r);
    endfunction

    function automatic void expect_leb(input leb_t e);
        for (int k = 0; k < e.n; k++)
            expect_byte(e.bytes[8*k +: 8], 1'b0);
    endfunction

    function automatic void predict_report(input logic [1:0] act, input logic [15:0] x,
                                           input logic [15:0] y, input logic [29:0] stamp);
        leb_t        st;
        leb_t        lx;
        leb_t        ly;
        leb_t        lz;
        logic [31:0] cmask;
        logic [7:0]  coord_len;
        cmask = (COORD_BITS >= 32) ? 32'hffff_ffff : ((32'h1 << COORD_BITS) - 32'h1);
        st = leb_encode({2'b00, stamp});
        lx = leb_encode({16'h0, x} & cmask);
        ly = leb_encode({16'h0, y} & cmask);
        lz = leb_encode(32'h0);
        coord_len = 8'(lx.n + ly.n + lz.n);
        for (int i = 0; i < 7; i++)
            expect_byte(REPORT_HEAD[8*(6-i) +: 8], 1'b0);
        expect_leb(st);
        expect_byte(SZ_OUTER, 1'b0);
        expect_byte(SZ_TOUCH + coord_len, 1'b0);
        expect_byte(SZ_LIST, 1'b0);
        expect_byte(SZ_POINT + coord_len, 1'b0);
        expect_byte(TAG_X, 1'b0);
        expect_leb(lx);
        expect_byte(TAG_Y, 1'b0);
        expect_leb(ly);
        expect_byte(TAG_Z, 1'b0);
        expect_leb(lz);
        for (int i = 0; i < 3; i++)
            expect_byte(REPORT_TAIL[8*(2-i) +: 8], 1'b0);
        expect_byte({6'b0, act}, 1'b1);
    endfunction

    function automatic void add_touch(input logic [1:0] a, input logic [15:0] x,
                                      input logic [15:0] y, input logic [29:0] s);
        touch_ev_t ev;
        ev.action = a;
        ev.x      = x;
        ev.y      = y;
        ev.stamp  = s;
        touch_q.push_back(ev);
    endfunction

    function automatic logic [15:0] rand_coord();
        logic [15:0] c;
        case ($urandom_range(0, 3))
            0:       c = 16'($urandom_range(0, 127));
            1:       c = 16'($urandom_range(128, 16383));
            2:       c = 16'($urandom_range(16384, 65535));
            default: c = 16'($urandom);
        endcase
        return c;
    endfunction

    // request side: bursts of requests separated by random gaps
    always @(negedge clk)
    begin
        touch_ev_t ev;
        logic      nxt_push;
        nxt_push = push;
        if (rst_n && !(push && !req_fire))
        begin
            if (req_fire)
                void'(touch_q.pop_front());
            if (gap_left > 0)
            begin
                gap_left--;
                nxt_push = 1'b0;
            end
            else if (touch_q.size() > 0)
            begin
                ev       = touch_q[0];
                nxt_push = 1'b1;
                action   <= ev.action;
                pos_x    <= ev.x;
                pos_y    <= ev.y;
                stamp_ns <= ev.stamp;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
                end
                else
                    burst_left--;
            end
            else
                nxt_push = 1'b0;
        end
        push <= nxt_push;
    end

    // result side: pattern of stalls plus one long hold-off to back up the queue
    always @(negedge clk)
    begin
        logic nxt_pop;
        nxt_pop = 1'b0;
        if (rst_n)
        begin
            if (!stall_done && events_in >= STALL_AFTER)
            begin
                stall_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
                stall_left--;
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                tick++;
                case (rx_mode)
                    RX_STREAM:   nxt_pop = 1'b1;
                    RX_COIN:     nxt_pop = 1'($urandom_range(0, 1));
                    RX_SPARSE:   nxt_pop = ($urandom_range(0, 4) == 0);
                    RX_PERIODIC: nxt_pop = (tick % 3 != 0);
                    default:     nxt_pop = 1'b1;
                endcase
            end
        end
        pop <= nxt_pop;
    end

    always @(posedge clk)
    begin
        report_byte_t r;
        if (!rst_n)
            req_fire <= 1'b0;
        else
        begin
            req_fire <= push && !full;
            if (push && full)
                full_cycles++;
            if (push && !full)
            begin
                predict_report(action, pos_x, pos_y, stamp_ns);
                events_in++;
            end
            if (pop && !empty)
            begin
                if (report_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                                 $time, out_byte, last);
                end
                else
                begin
                    r = report_q.pop_front();
                    bytes_seen++;
                    if (r.lst)
                        msgs_seen++;
                    if (out_byte !== r.b)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: out_byte: expected %02h, actual %02h",
                                     $time, r.b, out_byte);
                    end
                    if (last !== r.lst)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: last: expected %0b, actual %0b",
                                     $time, r.lst, last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d bytes still expected", $time, report_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [29:0] s;
        // LEB128 length boundaries, all-ones / all-zeros fields, undefined action
        add_touch(ACT_DOWN,  16'd0,     16'd0,     30'd0);
        add_touch(ACT_UP,    16'd127,   16'd127,   30'd127);
        add_touch(ACT_MOVE,  16'd128,   16'd128,   30'd128);
        add_touch(ACT_UNDEF, 16'd16383, 16'd16384, 30'd16383);
        add_touch(ACT_DOWN,  16'd16384, 16'd16383, 30'd16384);
        add_touch(ACT_UP,    16'hffff,  16'hffff,  30'd2097151);
        add_touch(ACT_MOVE,  16'hffff,  16'd0,     30'd2097152);
        add_touch(ACT_DOWN,  16'd0,     16'hffff,  30'd268435455);
        add_touch(ACT_UP,    16'd300,   16'd5,     30'd268435456);
        add_touch(ACT_MOVE,  16'd1,     16'hffff,  30'd999999999);
        add_touch(ACT_UNDEF, 16'hffff,  16'hffff,  30'd1000000000);
        add_touch(ACT_DOWN,  16'd0,     16'd0,     30'h3fffffff);
        add_touch(ACT_UP,    16'h5555,  16'haaaa,  30'h15555555);
        add_touch(ACT_MOVE,  16'haaaa,  16'h5555,  30'h2aaaaaaa);
        add_touch(ACT_UNDEF, 16'd0,     16'd0,     30'd0);
        for (int i = 0; i < RANDOM_EVENTS; i++)
        begin
            case ($urandom_range(0, 6))
                0:       s = 30'($urandom_range(0, 127));
                1:       s = 30'($urandom_range(128, 16383));
                2:       s = 30'($urandom_range(16384, 2097151));
                3:       s = 30'($urandom_range(2097152, 268435455));
                4:       s = 30'($urandom_range(268435456, 999999999));
                5:       s = 30'($urandom_range(1000000000, 32'h3fffffff));
                default: s = 30'($urandom);
            endcase
            add_touch(($urandom_range(0, 9) < 9) ? 2'($urandom_range(0, 2)) : ACT_UNDEF,
                      rand_coord(), rand_coord(), s);
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (touch_q.size() != 0 || push)
            @(posedge clk);
        while (report_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d touch events; checked %0d bytes in %0d report messages.",
                 events_in, bytes_seen, msgs_seen);
        $display("Input held off by a full queue for %0d cycles; %0d errors.",
                 full_cycles, errors);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
